/* hw/rtl/pfb_pkg.sv */
// Shared types and constants for the particle filter bounds unit.
// Used by pfb_front, pfb_queue, pfb_back and the top level.
package pfb_pkg;

   localparam int RAW_LON_W  = 21;
   localparam int NORM_W     = 22;
   localparam int LON_W      = 20;
   localparam int FOLD_W     = 19;
   localparam int LAT_W      = 18;
   localparam int HGT_W      = 18;
   localparam int SIZE_W     = 20;
   localparam int AGE_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 152;
   localparam int RSP_USER_W = 3;

   localparam logic signed [NORM_W-1:0] LON_FULL = 22'sd360000;
   localparam logic signed [NORM_W-1:0] LON_LOW  = -22'sd180000;
   localparam logic signed [NORM_W-1:0] LON_HALF = 22'sd180000;

   localparam logic signed [AGE_W-1:0] CUR_TIME_RST = 32'hFFFF_FFFF;
   localparam logic signed [HGT_W-1:0] HGT_FLOOR_RST = -18'sd10000;
   localparam logic signed [HGT_W-1:0] HGT_CEIL_RST  = 18'sd100000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_AIRBORNE_ONLY  = 3'd0,
      REG_FALLOUT_ONLY   = 3'd1,
      REG_CURRENT_TIME   = 3'd2,
      REG_HEIGHT_FLOOR   = 3'd3,
      REG_HEIGHT_CEILING = 3'd4,
      REG_SIZE_UPPER     = 3'd5,
      REG_SIZE_LOWER     = 3'd6
   } csr_addr_type;

   typedef struct packed {
      logic [LON_W-1:0]  lon;
      logic [FOLD_W-1:0] folded;
      logic [LAT_W-1:0]  lat;
      logic [HGT_W-1:0]  hgt;
      logic [SIZE_W-1:0] size;
      logic              pass;
      logic              last;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_max;
      logic [SIZE_W-1:0] size_min;
      logic [HGT_W-1:0]  hgt_max;
      logic [HGT_W-1:0]  hgt_min;
      logic [LAT_W-1:0]  lat_max;
      logic [LAT_W-1:0]  lat_min;
      logic [LON_W-1:0]  lon_max;
      logic [LON_W-1:0]  lon_min;
      logic              meridian_crossed;
      logic              any_valid;
      logic              item_valid;
      logic              summary_ready;
   } result_type;

endpackage

/* hw/rtl/pfb_front.sv */
// Front end: configuration registers, longitude normalization and particle filtering.
// Depends on pfb_pkg.
module pfb_front
   import pfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [RAW_LON_W-1:0]  longitude,
   input  logic [LAT_W-1:0]      latitude,
   input  logic [HGT_W-1:0]      height,
   input  logic [SIZE_W-1:0]     particle_size,
   input  logic [AGE_W-1:0]      particle_age,
   input  logic                  grounded,
   input  logic                  group_end,
   output item_type              item
);

   logic              airborne_only_ff;
   logic              fallout_only_ff;
   logic [AGE_W-1:0]  current_time_ff;
   logic [HGT_W-1:0]  height_floor_ff;
   logic [HGT_W-1:0]  height_ceiling_ff;
   logic [SIZE_W-1:0] size_upper_ff;
   logic [SIZE_W-1:0] size_lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         airborne_only_ff  <= 1'b0;
         fallout_only_ff   <= 1'b0;
         current_time_ff   <= CUR_TIME_RST;
         height_floor_ff   <= HGT_FLOOR_RST;
         height_ceiling_ff <= HGT_CEIL_RST;
         size_upper_ff     <= '0;
         size_lower_ff     <= '0;
      end else if (csr_wen) begin
         case (csr_addr_type'(csr_addr))
            REG_AIRBORNE_ONLY:  airborne_only_ff  <= csr_wdata[0];
            REG_FALLOUT_ONLY:   fallout_only_ff   <= csr_wdata[0];
            REG_CURRENT_TIME:   current_time_ff   <= csr_wdata[AGE_W-1:0];
            REG_HEIGHT_FLOOR:   height_floor_ff   <= csr_wdata[HGT_W-1:0];
            REG_HEIGHT_CEILING: height_ceiling_ff <= csr_wdata[HGT_W-1:0];
            REG_SIZE_UPPER:     size_upper_ff     <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_LOWER:     size_lower_ff     <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [NORM_W-1:0] raw_lon;
   logic signed [NORM_W-1:0] wrap_lon;
   logic signed [NORM_W-1:0] norm_lon;
   logic signed [NORM_W-1:0] fold_lon;
   logic                     pass;

   always_comb begin
      raw_lon = $signed({longitude[RAW_LON_W-1], longitude});
      if (raw_lon > LON_FULL) begin
         wrap_lon = raw_lon - LON_FULL;
      end else if (raw_lon < LON_LOW) begin
         wrap_lon = raw_lon + LON_FULL;
      end else begin
         wrap_lon = raw_lon;
      end
      if (wrap_lon > LON_FULL) begin
         norm_lon = LON_FULL;
      end else if (wrap_lon < LON_LOW) begin
         norm_lon = LON_LOW;
      end else begin
         norm_lon = wrap_lon;
      end
      fold_lon = (norm_lon > LON_HALF) ? norm_lon - LON_FULL : norm_lon;

      pass = 1'b1;
      if (grounded && airborne_only_ff) pass = 1'b0;
      if (!grounded && fallout_only_ff) pass = 1'b0;
      if (particle_age > current_time_ff) pass = 1'b0;
      if ($signed(height) > $signed(height_ceiling_ff)) pass = 1'b0;
      if ($signed(height) < $signed(height_floor_ff)) pass = 1'b0;
      if ((size_upper_ff != '0) && (particle_size > size_upper_ff)) pass = 1'b0;
      if ((size_lower_ff != '0) && (particle_size < size_lower_ff)) pass = 1'b0;

      item.lon    = norm_lon[LON_W-1:0];
      item.folded = fold_lon[FOLD_W-1:0];
      item.lat    = latitude;
      item.hgt    = height;
      item.size   = particle_size;
      item.pass   = pass;
      item.last   = group_end;
   end

endmodule

/* hw/rtl/pfb_queue.sv */
// Small FIFO of classified particles between the front end and the tracker.
// Depends on pfb_pkg.
module pfb_queue
   import pfb_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/pfb_back.sv */
// Back end: min/max trackers over passing particles and the response register.
// Depends on pfb_pkg.
module pfb_back
   import pfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       pop,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type rsp_result
);

   logic              seen_ff, seen_in, seen_cur;
   logic [LON_W-1:0]  lon_lo_ff, lon_lo_in, lon_lo_cur;
   logic [LON_W-1:0]  lon_hi_ff, lon_hi_in, lon_hi_cur;
   logic [FOLD_W-1:0] fld_lo_ff, fld_lo_in, fld_lo_cur;
   logic [FOLD_W-1:0] fld_hi_ff, fld_hi_in, fld_hi_cur;
   logic [LAT_W-1:0]  lat_lo_ff, lat_lo_in, lat_lo_cur;
   logic [LAT_W-1:0]  lat_hi_ff, lat_hi_in, lat_hi_cur;
   logic [HGT_W-1:0]  hgt_lo_ff, hgt_lo_in, hgt_lo_cur;
   logic [HGT_W-1:0]  hgt_hi_ff, hgt_hi_in, hgt_hi_cur;
   logic [SIZE_W-1:0] size_lo_ff, size_lo_in, size_lo_cur;
   logic [SIZE_W-1:0] size_hi_ff, size_hi_in, size_hi_cur;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;
   logic              upd;
   logic signed [LON_W:0] lon_span;

   assign pop        = q_valid && (!rsp_valid_ff || rsp_tready);
   assign upd        = pop && q_item.pass;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      seen_cur    = seen_ff;
      lon_lo_cur  = lon_lo_ff;
      lon_hi_cur  = lon_hi_ff;
      fld_lo_cur  = fld_lo_ff;
      fld_hi_cur  = fld_hi_ff;
      lat_lo_cur  = lat_lo_ff;
      lat_hi_cur  = lat_hi_ff;
      hgt_lo_cur  = hgt_lo_ff;
      hgt_hi_cur  = hgt_hi_ff;
      size_lo_cur = size_lo_ff;
      size_hi_cur = size_hi_ff;
      if (upd) begin
         seen_cur = 1'b1;
         if (!seen_ff) begin
            lon_lo_cur  = q_item.lon;
            lon_hi_cur  = q_item.lon;
            fld_lo_cur  = q_item.folded;
            fld_hi_cur  = q_item.folded;
            lat_lo_cur  = q_item.lat;
            lat_hi_cur  = q_item.lat;
            hgt_lo_cur  = q_item.hgt;
            hgt_hi_cur  = q_item.hgt;
            size_lo_cur = q_item.size;
            size_hi_cur = q_item.size;
         end else begin
            if ($signed(q_item.lon) < $signed(lon_lo_ff))    lon_lo_cur = q_item.lon;
            if ($signed(q_item.lon) > $signed(lon_hi_ff))    lon_hi_cur = q_item.lon;
            if ($signed(q_item.folded) < $signed(fld_lo_ff)) fld_lo_cur = q_item.folded;
            if ($signed(q_item.folded) > $signed(fld_hi_ff)) fld_hi_cur = q_item.folded;
            if ($signed(q_item.lat) < $signed(lat_lo_ff))    lat_lo_cur = q_item.lat;
            if ($signed(q_item.lat) > $signed(lat_hi_ff))    lat_hi_cur = q_item.lat;
            if ($signed(q_item.hgt) < $signed(hgt_lo_ff))    hgt_lo_cur = q_item.hgt;
            if ($signed(q_item.hgt) > $signed(hgt_hi_ff))    hgt_hi_cur = q_item.hgt;
            if (q_item.size < size_lo_ff)                    size_lo_cur = q_item.size;
            if (q_item.size > size_hi_ff)                    size_hi_cur = q_item.size;
         end
      end

      lon_span = $signed({lon_hi_cur[LON_W-1], lon_hi_cur})
               - $signed({lon_lo_cur[LON_W-1], lon_lo_cur});

      result_in               = '0;
      result_in.item_valid    = q_item.pass;
      result_in.summary_ready = q_item.last;
      if (q_item.last && seen_cur) begin
         result_in.any_valid = 1'b1;
         result_in.lon_min   = lon_lo_cur;
         result_in.lon_max   = lon_hi_cur;
         if (lon_span > LON_HALF[LON_W:0]) begin
            result_in.meridian_crossed = 1'b1;
            result_in.lon_min = {fld_lo_cur[FOLD_W-1], fld_lo_cur};
            result_in.lon_max = {fld_hi_cur[FOLD_W-1], fld_hi_cur};
         end
         result_in.lat_min  = lat_lo_cur;
         result_in.lat_max  = lat_hi_cur;
         result_in.hgt_min  = hgt_lo_cur;
         result_in.hgt_max  = hgt_hi_cur;
         result_in.size_min = size_lo_cur;
         result_in.size_max = size_hi_cur;
      end

      // group end clears every tracker
      if (pop && q_item.last) begin
         seen_in    = 1'b0;
         lon_lo_in  = '0;
         lon_hi_in  = '0;
         fld_lo_in  = '0;
         fld_hi_in  = '0;
         lat_lo_in  = '0;
         lat_hi_in  = '0;
         hgt_lo_in  = '0;
         hgt_hi_in  = '0;
         size_lo_in = '0;
         size_hi_in = '0;
      end else begin
         seen_in    = seen_cur;
         lon_lo_in  = lon_lo_cur;
         lon_hi_in  = lon_hi_cur;
         fld_lo_in  = fld_lo_cur;
         fld_hi_in  = fld_hi_cur;
         lat_lo_in  = lat_lo_cur;
         lat_hi_in  = lat_hi_cur;
         hgt_lo_in  = hgt_lo_cur;
         hgt_hi_in  = hgt_hi_cur;
         size_lo_in = size_lo_cur;
         size_hi_in = size_hi_cur;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         lon_lo_ff    <= '0;
         lon_hi_ff    <= '0;
         fld_lo_ff    <= '0;
         fld_hi_ff    <= '0;
         lat_lo_ff    <= '0;
         lat_hi_ff    <= '0;
         hgt_lo_ff    <= '0;
         hgt_hi_ff    <= '0;
         size_lo_ff   <= '0;
         size_hi_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         lon_lo_ff    <= lon_lo_in;
         lon_hi_ff    <= lon_hi_in;
         fld_lo_ff    <= fld_lo_in;
         fld_hi_ff    <= fld_hi_in;
         lat_lo_ff    <= lat_lo_in;
         lat_hi_ff    <= lat_hi_in;
         hgt_lo_ff    <= hgt_lo_in;
         hgt_hi_ff    <= hgt_hi_in;
         size_lo_ff   <= size_lo_in;
         size_hi_ff   <= size_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && q_item.last) |=> !seen_ff)
      else $error("trackers not cleared after group end");

   a_summary_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.summary_ready) |->
         (!result_ff.any_valid && !result_ff.meridian_crossed))
      else $error("summary flags on a non-final response");

   a_meridian_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.meridian_crossed) |-> result_ff.any_valid)
      else $error("meridian crossing without a passing particle");

   a_pop_seen: assert property (@(posedge clock) disable iff (reset)
      (pop && q_item.pass && !q_item.last) |=> seen_ff)
      else $error("passing particle not recorded");

endmodule

/* hw/rtl/particle_filter_bounds_unit.sv */
// Particle filter bounds unit: one particle per request, one response per request.
// Sustains one request per cycle while the response side is ready. An accepted request is
// written into the queue, then popped through the tracker update into the response register,
// which drives rsp_tvalid and the response fields. A stalled response side backs up into the
// QUEUE_DEPTH-entry queue, and req_tready drops only once that queue is full.
// Configuration writes take effect on the next cycle.
// Depends on pfb_pkg, pfb_front, pfb_queue and pfb_back.
module particle_filter_bounds_unit
   import pfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // longitude[20:0], latitude[38:21], height[56:39], particle_size[76:57],
   // particle_age[108:77], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // grounded
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // lon_min_out, lon_max_out, lat_min_out, lat_max_out, hgt_min_out, hgt_max_out,
   // size_min_out, size_max_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // item_valid, any_valid, meridian_crossed
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   item_type   front_item;
   item_type   q_item;
   logic       q_full;
   logic       q_valid;
   logic       q_pop;
   result_type result;

   assign req_tready = !q_full;

   pfb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .longitude     (req_tdata[20:0]),
      .latitude      (req_tdata[38:21]),
      .height        (req_tdata[56:39]),
      .particle_size (req_tdata[76:57]),
      .particle_age  (req_tdata[108:77]),
      .grounded      (req_tuser),
      .group_end     (req_tlast),
      .item          (front_item)
   );

   pfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   pfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (result)
   );

   assign rsp_tdata = {result.size_max, result.size_min, result.hgt_max, result.hgt_min,
                       result.lat_max, result.lat_min, result.lon_max, result.lon_min};
   assign rsp_tuser = {result.meridian_crossed, result.any_valid, result.item_valid};
   assign rsp_tlast = result.summary_ready;

endmodule

/* dv/tb_particle_filter_bounds_unit.sv */
// Self-checking testbench for particle_filter_bounds_unit: directed and random particle
// groups with per-request response prediction and random idling on both stream sides.
// Depends on pfb_pkg and the particle_filter_bounds_unit RTL.
module tb_particle_filter_bounds_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pfb_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   localparam int MAX_REPORTS = 10;
   localparam int WRAP        = int'(LON_FULL);
   localparam int WEST_EDGE   = int'(LON_LOW);
   localparam int HALF_TURN   = int'(LON_HALF);

   typedef struct {
      logic signed [RAW_LON_W-1:0] lon;
      logic signed [LAT_W-1:0]     lat;
      logic signed [HGT_W-1:0]     hgt;
      logic [SIZE_W-1:0]           psize;
      logic [AGE_W-1:0]            age;
      logic                        grounded;
      logic                        group_end;
   } particle_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // filter settings as the block should hold them
   logic              cfg_airborne   = 1'b0;
   logic              cfg_fallout    = 1'b0;
   logic [AGE_W-1:0]  cfg_now        = CUR_TIME_RST;
   int                cfg_floor      = int'(HGT_FLOOR_RST);
   int                cfg_ceiling    = int'(HGT_CEIL_RST);
   logic [SIZE_W-1:0] cfg_size_upper = '0;
   logic [SIZE_W-1:0] cfg_size_lower = '0;

   // bounds trackers of the current group
   bit                trk_seen = 1'b0;
   int                trk_lon_lo = 0, trk_lon_hi = 0, trk_fold_lo = 0, trk_fold_hi = 0;
   int                trk_lat_lo = 0, trk_lat_hi = 0, trk_hgt_lo = 0, trk_hgt_hi = 0;
   logic [SIZE_W-1:0] trk_size_lo = '0, trk_size_hi = '0;

   result_type predicted_bounds[$];
   int         mismatch_count = 0;
   bit         gaps_on = 1'b1;
   bit         stall_on = 1'b1;
   int         stall_left = 0;

   particle_filter_bounds_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic result_type track_particle(particle_type p);
      int         lon, fold, lat, hgt, lmin, lmax;
      logic       pass;
      result_type r;
      lon = int'(p.lon);
      lat = int'(p.lat);
      hgt = int'(p.hgt);
      if (lon > WRAP) lon -= WRAP;
      else if (lon < WEST_EDGE) lon += WRAP;
      if (lon > WRAP) lon = WRAP;
      if (lon < WEST_EDGE) lon = WEST_EDGE;
      fold = (lon > HALF_TURN) ? lon - WRAP : lon;

      pass = 1'b1;
      if (p.grounded && cfg_airborne) pass = 1'b0;
      if (!p.grounded && cfg_fallout) pass = 1'b0;
      if (p.age > cfg_now) pass = 1'b0;
      if (hgt > cfg_ceiling || hgt < cfg_floor) pass = 1'b0;
      if (cfg_size_upper != 0 && p.psize > cfg_size_upper) pass = 1'b0;
      if (cfg_size_lower != 0 && p.psize < cfg_size_lower) pass = 1'b0;

      if (pass && !trk_seen) begin
         trk_lon_lo = lon;  trk_lon_hi = lon;
         trk_fold_lo = fold; trk_fold_hi = fold;
         trk_lat_lo = lat;  trk_lat_hi = lat;
         trk_hgt_lo = hgt;  trk_hgt_hi = hgt;
         trk_size_lo = p.psize; trk_size_hi = p.psize;
         trk_seen = 1'b1;
      end else if (pass) begin
         if (lon < trk_lon_lo) trk_lon_lo = lon;
         if (lon > trk_lon_hi) trk_lon_hi = lon;
         if (fold < trk_fold_lo) trk_fold_lo = fold;
         if (fold > trk_fold_hi) trk_fold_hi = fold;
         if (lat < trk_lat_lo) trk_lat_lo = lat;
         if (lat > trk_lat_hi) trk_lat_hi = lat;
         if (hgt < trk_hgt_lo) trk_hgt_lo = hgt;
         if (hgt > trk_hgt_hi) trk_hgt_hi = hgt;
         if (p.psize < trk_size_lo) trk_size_lo = p.psize;
         if (p.psize > trk_size_hi) trk_size_hi = p.psize;
      end

      r = '0;
      r.item_valid    = pass;
      r.summary_ready = p.group_end;
      if (p.group_end) begin
         if (trk_seen) begin
            r.any_valid = 1'b1;
            lmin = trk_lon_lo;
            lmax = trk_lon_hi;
            if (trk_lon_hi - trk_lon_lo > HALF_TURN) begin
               lmin = trk_fold_lo;
               lmax = trk_fold_hi;
               r.meridian_crossed = 1'b1;
            end
            r.lon_min  = lmin[LON_W-1:0];
            r.lon_max  = lmax[LON_W-1:0];
            r.lat_min  = trk_lat_lo[LAT_W-1:0];
            r.lat_max  = trk_lat_hi[LAT_W-1:0];
            r.hgt_min  = trk_hgt_lo[HGT_W-1:0];
            r.hgt_max  = trk_hgt_hi[HGT_W-1:0];
            r.size_min = trk_size_lo;
            r.size_max = trk_size_hi;
         end
         trk_seen = 1'b0;
         trk_lon_lo = 0;  trk_lon_hi = 0;  trk_fold_lo = 0; trk_fold_hi = 0;
         trk_lat_lo = 0;  trk_lat_hi = 0;  trk_hgt_lo = 0;  trk_hgt_hi = 0;
         trk_size_lo = '0; trk_size_hi = '0;
      end
      return r;
   endfunction

   function automatic particle_type make_particle(int lon, int lat, int hgt,
                                                  logic [SIZE_W-1:0] psize,
                                                  logic [AGE_W-1:0] age,
                                                  logic grounded, logic group_end);
      particle_type p;
      p.lon       = RAW_LON_W'(lon);
      p.lat       = LAT_W'(lat);
      p.hgt       = HGT_W'(hgt);
      p.psize     = psize;
      p.age       = age;
      p.grounded  = grounded;
      p.group_end = group_end;
      return p;
   endfunction

   // mostly particles that pass the current filters, some raw noise
   function automatic particle_type rand_particle(logic group_end, bit cluster, int centre);
      particle_type p;
      int           lo_s, hi_s;
      if ($urandom_range(0, 4) == 0) begin
         p.lon      = RAW_LON_W'($urandom);
         p.lat      = LAT_W'($urandom);
         p.hgt      = HGT_W'($urandom);
         p.psize    = SIZE_W'($urandom);
         p.age      = $urandom;
         p.grounded = 1'($urandom_range(0, 1));
      end else begin
         if (cluster) p.lon = RAW_LON_W'(centre + int'($urandom_range(0, 60000)) - 30000);
         else p.lon = RAW_LON_W'(int'($urandom_range(0, 1260000)) - 540000);
         p.lat = LAT_W'(int'($urandom_range(0, 180000)) - 90000);
         if (cfg_floor <= cfg_ceiling)
            p.hgt = HGT_W'(cfg_floor + int'($urandom_range(0, cfg_ceiling - cfg_floor)));
         else
            p.hgt = HGT_W'(int'($urandom_range(0, 110000)) - 10000);
         lo_s = int'(cfg_size_lower);
         hi_s = (cfg_size_upper != 0) ? int'(cfg_size_upper) : (1 << SIZE_W) - 1;
         if (lo_s <= hi_s) p.psize = SIZE_W'($urandom_range(hi_s, lo_s));
         else p.psize = SIZE_W'($urandom);
         if (cfg_now == '1) p.age = $urandom;
         else p.age = $urandom_range(cfg_now, 0);
         if ($urandom_range(0, 7) == 0) p.age = $urandom;
         p.grounded = cfg_fallout ? 1'b1 : cfg_airborne ? 1'b0 : 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) p.grounded = ~p.grounded;
      end
      p.group_end = group_end;
      return p;
   endfunction

   task automatic send_particle(particle_type p);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'({p.age, p.psize, p.hgt, p.lat, p.lon});
      req_tuser  <= p.grounded;
      req_tlast  <= p.group_end;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_bounds.push_back(track_particle(p));
   endtask

   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (predicted_bounds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_AIRBORNE_ONLY:  cfg_airborne   = val[0];
         REG_FALLOUT_ONLY:   cfg_fallout    = val[0];
         REG_CURRENT_TIME:   cfg_now        = val;
         REG_HEIGHT_FLOOR:   cfg_floor      = int'($signed(val[HGT_W-1:0]));
         REG_HEIGHT_CEILING: cfg_ceiling    = int'($signed(val[HGT_W-1:0]));
         REG_SIZE_UPPER:     cfg_size_upper = val[SIZE_W-1:0];
         REG_SIZE_LOWER:     cfg_size_lower = val[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   // setting 0 opens every filter, setting 1 is the tightest, others random
   task automatic configure_filters(int setting);
      logic [31:0]       junk, now;
      logic              air, fall;
      int                fl, ce, tmp;
      logic [SIZE_W-1:0] su, sl;
      junk = $urandom;
      case (setting)
         0: begin
            air = 1'b0; fall = 1'b0; now = '1;
            fl = -(1 << (HGT_W - 1)); ce = (1 << (HGT_W - 1)) - 1;
            su = '0; sl = '0;
         end
         1: begin
            air = 1'b1; fall = 1'b0; now = '0;
            fl = -10000; ce = -10000;
            su = '1; sl = '1;
         end
         default: begin
            air  = ($urandom_range(0, 3) == 0);
            fall = ($urandom_range(0, 4) == 0);
            now  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
            fl = int'($urandom_range(0, 110000)) - 10000;
            ce = int'($urandom_range(0, 110000)) - 10000;
            if (fl > ce && $urandom_range(0, 7) != 0) begin
               tmp = fl; fl = ce; ce = tmp;
            end
            su = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(1, (1 << SIZE_W) - 1));
            sl = $urandom_range(0, 1) ? '0 :
                 SIZE_W'($urandom_range(1, (su == 0) ? (1 << SIZE_W) - 1 : int'(su)));
         end
      endcase
      write_reg(REG_AIRBORNE_ONLY,  {junk[31:1], air});
      write_reg(REG_FALLOUT_ONLY,   {junk[30:0], fall});
      write_reg(REG_CURRENT_TIME,   now);
      write_reg(REG_HEIGHT_FLOOR,   {junk[31:HGT_W], fl[HGT_W-1:0]});
      write_reg(REG_HEIGHT_CEILING, {junk[HGT_W-1:4], ce[HGT_W-1:0]});
      write_reg(REG_SIZE_UPPER,     {junk[31:SIZE_W], su});
      write_reg(REG_SIZE_LOWER,     {junk[SIZE_W-1:8], sl});
   endtask

   task automatic send_groups(int n_items);
      int sent, len, centre;
      bit cluster;
      sent = 0;
      while (sent < n_items) begin
         len     = $urandom_range(1, 10);
         cluster = ($urandom_range(0, 2) == 0);
         centre  = int'($urandom_range(0, 540000)) - 180000;
         for (int k = 0; k < len; k++)
            send_particle(rand_particle(k == len - 1, cluster, centre));
         sent += len;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected 'h%0h actual 'h%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         // tdata lines up with the bounds fields of result_type
         got = {rsp_tdata, rsp_tuser[2], rsp_tuser[1], rsp_tuser[0], rsp_tlast};
         if (predicted_bounds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("response with no request pending: 'h%0h", got);
         end else begin
            want = predicted_bounds.pop_front();
            check_field("item_valid", want.item_valid, got.item_valid);
            check_field("summary_ready", want.summary_ready, got.summary_ready);
            check_field("any_valid", want.any_valid, got.any_valid);
            check_field("meridian_crossed", want.meridian_crossed, got.meridian_crossed);
            check_field("lon_min", want.lon_min, got.lon_min);
            check_field("lon_max", want.lon_max, got.lon_max);
            check_field("lat_min", want.lat_min, got.lat_min);
            check_field("lat_max", want.lat_max, got.lat_max);
            check_field("hgt_min", want.hgt_min, got.hgt_min);
            check_field("hgt_max", want.hgt_max, got.hgt_max);
            check_field("size_min", want.size_min, got.size_min);
            check_field("size_max", want.size_max, got.size_max);
         end
      end
   end

   task automatic test_longitude_and_extremes();
      // wrap, clamp, field extremes; span over a half turn gives folded bounds
      send_particle(make_particle(720000, 90000, 100000, '1, '1, 1'b1, 1'b0));
      send_particle(make_particle(-540000, -90000, -10000, '0, '0, 1'b0, 1'b0));
      send_particle(make_particle(1048575, 1, 5, 1, 7, 1'b0, 1'b0));
      send_particle(make_particle(-1048576, 0, 0, 2, 8, 1'b1, 1'b0));
      send_particle(make_particle(100, 131071, 131071, 3, 9, 1'b0, 1'b0));
      send_particle(make_particle(200000, -131072, -131072, 4, 10, 1'b0, 1'b0));
      send_particle(make_particle(200000, 45000, 50000, 1000, 100, 1'b0, 1'b1));
      send_particle(make_particle(10000, -45000, 0, 500, 0, 1'b1, 1'b1));
      // span of exactly a half turn stays unfolded
      send_particle(make_particle(0, 0, 0, 10, 0, 1'b0, 1'b0));
      send_particle(make_particle(180000, 0, 0, 10, 0, 1'b0, 1'b1));
   endtask

   task automatic test_grounded_modes();
      await_idle();
      write_reg(REG_AIRBORNE_ONLY, 32'h0000_0001);
      send_particle(make_particle(1000, 1000, 100, 10, 0, 1'b1, 1'b0));
      send_particle(make_particle(2000, 2000, 200, 20, 0, 1'b0, 1'b1));
      await_idle();
      write_reg(REG_FALLOUT_ONLY, 32'h0000_0001);
      send_particle(make_particle(3000, 3000, 300, 30, 0, 1'b0, 1'b0));
      send_particle(make_particle(4000, 4000, 400, 40, 0, 1'b1, 1'b1));
      await_idle();
      write_reg(REG_AIRBORNE_ONLY, 32'hFFFF_FFFE);
      send_particle(make_particle(5000, 5000, 500, 50, 0, 1'b0, 1'b0));
      send_particle(make_particle(6000, 6000, 600, 60, 0, 1'b1, 1'b1));
      await_idle();
      write_reg(REG_FALLOUT_ONLY, 32'h0000_0000);
   endtask

   task automatic test_filter_windows();
      await_idle();
      write_reg(REG_CURRENT_TIME, 32'd1000);
      send_particle(make_particle(0, 0, 0, 5, 1000, 1'b0, 1'b0));
      send_particle(make_particle(0, 0, 0, 5, 1001, 1'b0, 1'b1));
      await_idle();
      // floor above ceiling rejects everything
      write_reg(REG_HEIGHT_FLOOR, 32'd500);
      write_reg(REG_HEIGHT_CEILING, 32'd400);
      send_particle(make_particle(0, 0, 450, 5, 0, 1'b0, 1'b1));
      await_idle();
      write_reg(REG_HEIGHT_FLOOR, 32'hFFFE_0000);
      write_reg(REG_HEIGHT_CEILING, 32'h5A01_FFFF);
      write_reg(REG_CURRENT_TIME, 32'hFFFF_FFFF);
      write_reg(REG_SIZE_UPPER, 32'd100);
      write_reg(REG_SIZE_LOWER, 32'd50);
      send_particle(make_particle(-100, 10, 10, 49, 0, 1'b0, 1'b0));
      send_particle(make_particle(-200, 20, 20, 50, 0, 1'b0, 1'b0));
      send_particle(make_particle(-300, 30, 30, 100, 0, 1'b1, 1'b0));
      send_particle(make_particle(-400, 40, 40, 101, 0, 1'b1, 1'b1));
      await_idle();
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_particle(make_particle(0, 0, -131072, 75, 0, 1'b1, 1'b1));
      await_idle();
      write_reg(REG_SIZE_UPPER, 32'hFFF0_0000);
      write_reg(REG_SIZE_LOWER, 32'h0000_0000);
   endtask

   task automatic test_random_phases();
      for (int setting = 0; setting < 6; setting++) begin
         await_idle();
         configure_filters(setting);
         send_groups(50);
         // let the pipeline drain completely mid-phase
         if (setting == 2) await_idle();
         send_groups(50);
      end
   endtask

   task automatic test_steady_stream();
      await_idle();
      configure_filters(0);
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      send_groups(100);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_longitude_and_extremes();
      test_grounded_modes();
      test_filter_windows();
      test_random_phases();
      test_steady_stream();
      await_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && predicted_bounds.size() == 0) begin
         $display("particle_filter_bounds_unit verification clean");
      end else begin
         $display("particle_filter_bounds_unit verification failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("particle_filter_bounds_unit verification failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_front.sv
hw/rtl/pfb_queue.sv
hw/rtl/pfb_back.sv
hw/rtl/particle_filter_bounds_unit.sv
dv/tb_particle_filter_bounds_unit.sv
